// ===== hw/rtl/ufrr_pkg.sv =====
// Shared types and constants of the urgent-first round-robin dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package ufrr_pkg;

   localparam int CountW     = 5;
   localparam int ClientW    = 4;
   localparam int GoalW      = 4;
   localparam int PayloadW   = 32;
   localparam int UrgentW    = 16;
   localparam int CsrIndexW  = 8;
   localparam int CsrDataW   = 32;
   localparam int GoalKinds  = 8;
   localparam int ResetCount = 16;

   typedef enum logic [1:0] {
      FUNC_POLL   = 2'd0,
      FUNC_TAKE   = 2'd1,
      FUNC_RESULT = 2'd2,
      FUNC_SPARE  = 2'd3
   } func_type;

   localparam logic [CsrIndexW-1:0] CSR_ADVISOR_ENABLED = 8'd0;
   localparam logic [CsrIndexW-1:0] CSR_CLIENT_COUNT    = 8'd1;

   // Status returned by the winner scan to the top-level sequencer.
   typedef struct packed {
      logic done;
      logic found;
   } scan_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ufrr_if.sv =====
// Handshake channel interfaces for requests, responses and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface ufrr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [3:0]  client_index;
   logic        request;
   logic [15:0] urgent_mask;
   logic [3:0]  result_goal;
   logic [31:0] result_payload;

   modport source (output valid, func, client_index, request, urgent_mask,
                   result_goal, result_payload, input ready);
   modport sink   (input valid, func, client_index, request, urgent_mask,
                   result_goal, result_payload, output ready);
endinterface

interface ufrr_rsp_if;
   logic        valid;
   logic        ready;
   logic        delivered;
   logic [3:0]  goal_out;
   logic [31:0] payload_out;
   logic        client_valid;
   logic [3:0]  client_out;

   modport source (output valid, delivered, goal_out, payload_out, client_valid,
                   client_out, input ready);
   modport sink   (input valid, delivered, goal_out, payload_out, client_valid,
                   client_out, output ready);
endinterface

interface ufrr_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ufrr_scan.sv =====
// Iterative winner scan: reduces the rotation start, then walks clients in two passes.
`timescale 1ns / 1ps
`default_nettype none

module ufrr_scan
   import ufrr_pkg::*;
#(
   parameter int MAX_CLIENTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [MAX_CLIENTS-1:0]          pending,
   input  logic [UrgentW-1:0]              urgent,
   input  logic [$clog2(MAX_CLIENTS)-1:0]  pointer,
   input  logic [CountW-1:0]               count,
   output scan_stat_type                   stat,
   output logic [$clog2(MAX_CLIENTS)-1:0]  winner
);

   localparam int PW = $clog2(MAX_CLIENTS);

   typedef enum logic [2:0] {
      SC_IDLE = 3'b001,
      SC_MOD  = 3'b010,
      SC_SCAN = 3'b100
   } sc_state_type;

   sc_state_type      state_ff, state_in;
   logic [PW-1:0]     start_ff, start_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [CountW-1:0] step_ff, step_in;
   logic              pass_ff, pass_in;

   logic [31:0]       pos_ext;
   logic              urgent_bit;
   logic              hit;

   assign pos_ext    = 32'(pos_ff);
   // Clients at sixteen and above have no urgent bit.
   assign urgent_bit = (pos_ext < 32'(UrgentW)) && urgent[pos_ext[3:0]];
   assign hit        = pending[pos_ff] && (pass_ff || urgent_bit);
   assign winner     = pos_ff;

   always_comb begin
      state_in   = state_ff;
      start_in   = start_ff;
      pos_in     = pos_ff;
      step_in    = step_ff;
      pass_in    = pass_ff;
      stat.done  = 1'b0;
      stat.found = 1'b0;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               start_in = pointer;
               state_in = SC_MOD;
            end
         end
         SC_MOD: begin
            // A stale pointer is brought below the count by repeated subtraction.
            if (32'(start_ff) >= 32'(count)) begin
               start_in = PW'(32'(start_ff) - 32'(count));
            end else begin
               pos_in   = start_ff;
               step_in  = '0;
               pass_in  = 1'b0;
               state_in = SC_SCAN;
            end
         end
         SC_SCAN: begin
            if (hit) begin
               stat.done  = 1'b1;
               stat.found = 1'b1;
               state_in   = SC_IDLE;
            end else if (32'(step_ff) + 1 == 32'(count)) begin
               if (pass_ff) begin
                  stat.done = 1'b1;
                  state_in  = SC_IDLE;
               end else begin
                  pass_in = 1'b1;
                  step_in = '0;
                  pos_in  = start_ff;
               end
            end else begin
               step_in = CountW'(32'(step_ff) + 1);
               if (32'(pos_ff) + 1 == 32'(count)) begin
                  pos_in = '0;
               end else begin
                  pos_in = PW'(32'(pos_ff) + 1);
               end
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      start_ff <= start_in;
      pos_ff   <= pos_in;
      step_ff  <= step_in;
      pass_ff  <= pass_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/urgent_first_round_robin_dispatcher.sv =====
// Top level of the urgent-first round-robin dispatcher with its sequencer and state.
//
//   channel   direction   signals
//   req_ch    in          valid ready func client_index request urgent_mask
//                         result_goal result_payload
//   rsp_ch    out         valid ready delivered goal_out payload_out client_valid client_out
//   csr_ch    in          valid ready index data (index 0 enable, 1 client count)
//
// Every request passes through accept, execute and write, plus the winner scan when a
// poll may dispatch; the scan first brings the rotation pointer below the active client
// count by repeated subtraction. The scan unit walks one client per cycle. Reset is
// synchronous; it sets the client count to sixteen and clears the other control state.
// A response waits in the output register; the next request is accepted meanwhile
// and stalls in its write cycle only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module urgent_first_round_robin_dispatcher
   import ufrr_pkg::*;
#(
   parameter int MAX_CLIENTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ufrr_req_if.sink   req_ch,
   ufrr_rsp_if.source rsp_ch,
   ufrr_csr_if.sink   csr_ch
);

   localparam int PW = $clog2(MAX_CLIENTS);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_SCAN  = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic                   enable_ff, enable_in;
   logic [CountW-1:0]      count_ff, count_in;

   func_type               func_ff, func_in;
   logic [ClientW-1:0]     idx_ff, idx_in;
   logic                   request_ff, request_in;
   logic [UrgentW-1:0]     urgent_ff, urgent_in;
   logic [GoalW-1:0]       goal_ff, goal_in;
   logic [PayloadW-1:0]    payload_ff, payload_in;

   logic [MAX_CLIENTS-1:0] pending_ff, pending_in;
   logic [PW-1:0]          ptr_ff, ptr_in;
   logic                   box_full_ff, box_full_in;
   logic [ClientW-1:0]     box_client_ff, box_client_in;
   logic                   busy_ff, busy_in;
   logic                   answer_ready_ff, answer_ready_in;
   logic [ClientW-1:0]     answer_client_ff, answer_client_in;
   logic [GoalW-1:0]       answer_goal_ff, answer_goal_in;
   logic [PayloadW-1:0]    answer_payload_ff, answer_payload_in;

   logic                   res_delivered_ff, res_delivered_in;
   logic [GoalW-1:0]       res_goal_ff, res_goal_in;
   logic [PayloadW-1:0]    res_payload_ff, res_payload_in;
   logic                   res_cvalid_ff, res_cvalid_in;
   logic [ClientW-1:0]     res_client_ff, res_client_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_delivered_ff, rsp_delivered_in;
   logic [GoalW-1:0]       rsp_goal_ff, rsp_goal_in;
   logic [PayloadW-1:0]    rsp_payload_ff, rsp_payload_in;
   logic                   rsp_cvalid_ff, rsp_cvalid_in;
   logic [ClientW-1:0]     rsp_client_ff, rsp_client_in;

   logic [CountW-1:0]      act_count;
   logic                   poll_ok;
   logic [MAX_CLIENTS-1:0] idx_bit;
   logic [MAX_CLIENTS-1:0] pending_eff;
   logic                   scan_start;
   scan_stat_type          scan_stat;
   logic [PW-1:0]          scan_winner;
   logic                   slot_free;

   assign act_count   = (32'(count_ff) > MAX_CLIENTS) ? CountW'(MAX_CLIENTS) : count_ff;
   assign poll_ok     = enable_ff && ({1'b0, idx_ff} < act_count);
   assign idx_bit     = MAX_CLIENTS'(1) << idx_ff;
   assign pending_eff = request_ff ? (pending_ff | idx_bit) : pending_ff;
   assign slot_free   = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.delivered    = rsp_delivered_ff;
   assign rsp_ch.goal_out     = rsp_goal_ff;
   assign rsp_ch.payload_out  = rsp_payload_ff;
   assign rsp_ch.client_valid = rsp_cvalid_ff;
   assign rsp_ch.client_out   = rsp_client_ff;

   ufrr_scan #(
      .MAX_CLIENTS (MAX_CLIENTS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .pending (pending_ff),
      .urgent  (urgent_ff),
      .pointer (ptr_ff),
      .count   (act_count),
      .stat    (scan_stat),
      .winner  (scan_winner)
   );

   always_comb begin
      state_in          = state_ff;
      enable_in         = enable_ff;
      count_in          = count_ff;
      func_in           = func_ff;
      idx_in            = idx_ff;
      request_in        = request_ff;
      urgent_in         = urgent_ff;
      goal_in           = goal_ff;
      payload_in        = payload_ff;
      pending_in        = pending_ff;
      ptr_in            = ptr_ff;
      box_full_in       = box_full_ff;
      box_client_in     = box_client_ff;
      busy_in           = busy_ff;
      answer_ready_in   = answer_ready_ff;
      answer_client_in  = answer_client_ff;
      answer_goal_in    = answer_goal_ff;
      answer_payload_in = answer_payload_ff;
      res_delivered_in  = res_delivered_ff;
      res_goal_in       = res_goal_ff;
      res_payload_in    = res_payload_ff;
      res_cvalid_in     = res_cvalid_ff;
      res_client_in     = res_client_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_delivered_in  = rsp_delivered_ff;
      rsp_goal_in       = rsp_goal_ff;
      rsp_payload_in    = rsp_payload_ff;
      rsp_cvalid_in     = rsp_cvalid_ff;
      rsp_client_in     = rsp_client_ff;
      scan_start        = 1'b0;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ADVISOR_ENABLED: enable_in = csr_ch.data[0];
            CSR_CLIENT_COUNT:    count_in  = csr_ch.data[CountW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               func_in    = func_type'(req_ch.func);
               idx_in     = req_ch.client_index;
               request_in = req_ch.request;
               urgent_in  = req_ch.urgent_mask;
               goal_in    = req_ch.result_goal;
               payload_in = req_ch.result_payload;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            res_delivered_in = 1'b0;
            res_goal_in      = '0;
            res_payload_in   = '0;
            res_cvalid_in    = 1'b0;
            res_client_in    = '0;
            state_in         = S_WRITE;
            unique case (func_ff)
               FUNC_POLL: begin
                  if (poll_ok) begin
                     // A waiting answer is consumed even when its goal is garbage.
                     if (answer_ready_ff && answer_client_ff == idx_ff) begin
                        if (32'(answer_goal_ff) < GoalKinds) begin
                           res_delivered_in = 1'b1;
                           res_goal_in      = answer_goal_ff;
                           res_payload_in   = answer_payload_ff;
                        end
                        answer_ready_in = 1'b0;
                     end
                     pending_in = pending_eff;
                     if (!busy_ff && !box_full_ff && |(pending_eff & idx_bit)) begin
                        scan_start = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
               end
               FUNC_TAKE: begin
                  if (box_full_ff) begin
                     box_full_in   = 1'b0;
                     busy_in       = 1'b1;
                     res_cvalid_in = 1'b1;
                     res_client_in = box_client_ff;
                  end
               end
               FUNC_RESULT: begin
                  if (busy_ff) begin
                     busy_in           = 1'b0;
                     answer_ready_in   = 1'b1;
                     answer_client_in  = box_client_ff;
                     answer_goal_in    = goal_ff;
                     answer_payload_in = payload_ff;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (scan_stat.done) begin
               // The poller is dispatched only if it is the scan's winner.
               if (scan_stat.found && 32'(scan_winner) == 32'(idx_ff)) begin
                  pending_in    = pending_ff & ~idx_bit;
                  box_full_in   = 1'b1;
                  box_client_in = idx_ff;
                  res_cvalid_in = 1'b1;
                  res_client_in = idx_ff;
                  if (32'(idx_ff) + 1 == 32'(act_count)) begin
                     ptr_in = '0;
                  end else begin
                     ptr_in = PW'(32'(idx_ff) + 1);
                  end
               end
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_delivered_in = res_delivered_ff;
               rsp_goal_in      = res_goal_ff;
               rsp_payload_in   = res_payload_ff;
               rsp_cvalid_in    = res_cvalid_ff;
               rsp_client_in    = res_client_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         enable_ff        <= 1'b0;
         count_ff         <= CountW'(ResetCount);
         pending_ff       <= '0;
         ptr_ff           <= '0;
         box_full_ff      <= 1'b0;
         box_client_ff    <= '0;
         busy_ff          <= 1'b0;
         answer_ready_ff  <= 1'b0;
         answer_client_ff <= '0;
         answer_goal_ff   <= '0;
         answer_payload_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         enable_ff        <= enable_in;
         count_ff         <= count_in;
         pending_ff       <= pending_in;
         ptr_ff           <= ptr_in;
         box_full_ff      <= box_full_in;
         box_client_ff    <= box_client_in;
         busy_ff          <= busy_in;
         answer_ready_ff  <= answer_ready_in;
         answer_client_ff <= answer_client_in;
         answer_goal_ff   <= answer_goal_in;
         answer_payload_ff <= answer_payload_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      func_ff          <= func_in;
      idx_ff           <= idx_in;
      request_ff       <= request_in;
      urgent_ff        <= urgent_in;
      goal_ff          <= goal_in;
      payload_ff       <= payload_in;
      res_delivered_ff <= res_delivered_in;
      res_goal_ff      <= res_goal_in;
      res_payload_ff   <= res_payload_in;
      res_cvalid_ff    <= res_cvalid_in;
      res_client_ff    <= res_client_in;
      rsp_delivered_ff <= rsp_delivered_in;
      rsp_goal_ff      <= rsp_goal_in;
      rsp_payload_ff   <= rsp_payload_in;
      rsp_cvalid_ff    <= rsp_cvalid_in;
      rsp_client_ff    <= rsp_client_in;
   end

   // The box and the worker never hold a client at the same time.
   a_box_or_worker : assert property (@(posedge clock) disable iff (reset)
      !(box_full_ff && busy_ff))
      else $error("box full while worker busy");

   // An answer appears only when the worker finishes.
   a_answer_from_worker : assert property (@(posedge clock) disable iff (reset)
      $rose(answer_ready_ff) |-> $fell(busy_ff))
      else $error("answer without worker result");

   // A client is placed in the box only while the worker is idle.
   a_fill_when_idle : assert property (@(posedge clock) disable iff (reset)
      $rose(box_full_ff) |-> $past(!busy_ff))
      else $error("box filled while worker busy");

   // A response is loaded only from the write cycle.
   a_rsp_from_write : assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) || (rsp_valid_ff && $past(rsp_ch.ready))) |->
         $past(state_ff == S_WRITE))
      else $error("response loaded outside write cycle");

endmodule

`default_nettype wire
